// ===== rtl/core/wltm_pkg.sv =====
// Shared types and constants of the word list text masker.
package wltm_pkg;

  localparam int unsigned WordSlots = 16;
  localparam int unsigned WordMax   = 16;
  localparam int unsigned MsgMax    = 256;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned WposW     = 4;
  localparam int unsigned MposW     = 8;
  localparam int unsigned CntW      = 9;
  localparam int unsigned LenW      = 5;

  localparam logic [7:0] FillLight = 8'h2A;
  localparam logic [7:0] FillHeavy = 8'h23;

  localparam logic [1:0] OpWordByte = 2'd0;
  localparam logic [1:0] OpWordLen  = 2'd1;
  localparam logic [1:0] OpPush     = 2'd2;
  localparam logic [1:0] OpRead     = 2'd3;

  localparam logic [1:0] LevelNone  = 2'd0;
  localparam logic [1:0] LevelHeavy = 2'd3;

  localparam logic [0:0] RegFilterLevel = 1'd0;
  localparam logic [0:0] RegMatureOn    = 1'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] slot;
    logic [7:0] position;
    logic [7:0] data_byte;
    logic [4:0] word_length;
    logic       skip_word;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [8:0] message_length;
    logic       done_res;
    logic       overflow;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic do_cmd;      // execute the accepted command
    logic mask_begin;  // start scan of slot 0
    logic cmp_step;    // advance the scan: fetch, compare, fill byte or next slot
    logic result;      // emit the result word
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_mask;   // push with last, masking enabled and a word length set
    logic scan_done;   // all slots scanned
  } dp_stat_t;

  // ASCII upper to lower
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

// ===== rtl/core/wltm_ctrl.sv =====
// Sequencing state machine of the masker.
module wltm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  wltm_pkg::dp_stat_t  stat_i,
  output wltm_pkg::ctl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StExec = 4'b0010,
    StScan = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StExec;
      end
      StExec: begin
        cmd_o.do_cmd = 1'b1;
        if (stat_i.need_mask) begin
          cmd_o.mask_begin = 1'b1;
          state_d = StScan;
        end else begin
          state_d = StDone;
        end
      end
      StScan: begin
        cmd_o.cmp_step = 1'b1;
        if (stat_i.scan_done) state_d = StDone;
      end
      StDone: begin
        cmd_o.result = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

// ===== rtl/core/wltm_dp.sv =====
// Datapath: word table, message buffer and the character compare scanner.
module wltm_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  wltm_pkg::in_word_t   in_i,
  input  logic [1:0]           filter_level_i,
  input  logic                 mature_on_i,
  input  wltm_pkg::ctl_cmd_t   cmd_i,
  output wltm_pkg::dp_stat_t   stat_o,
  output logic                 res_valid_o,
  output wltm_pkg::out_word_t  res_o
);

  localparam int unsigned WaddrW = wltm_pkg::SlotW + wltm_pkg::WposW;

  logic [7:0] word_mem [wltm_pkg::WordSlots*wltm_pkg::WordMax];
  logic [7:0] msg_mem  [wltm_pkg::MsgMax];
  logic [wltm_pkg::LenW-1:0] len_q [wltm_pkg::WordSlots];
  logic [wltm_pkg::WordSlots-1:0] skip_q;

  wltm_pkg::in_word_t cmd_q;
  logic [wltm_pkg::CntW-1:0] count_q;
  logic done_q, ovf_q;
  logic [7:0] rd_q;

  // scanner state
  logic [wltm_pkg::SlotW-1:0] s_q;
  logic [wltm_pkg::CntW-1:0]  pos_q;
  logic [wltm_pkg::WposW:0]   k_q;
  logic                       fill_mode_q;   // writing fill bytes
  logic                       fetched_q;     // mb_q/wb_q hold the current pair
  logic                       scan_end_q;
  logic [7:0]                 fill_q;
  logic [7:0]                 mb_q, wb_q;    // registered memory reads

  // latch command on accept
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i) cmd_q <= in_i;
  end

  // effective count seen by this push
  logic [wltm_pkg::CntW-1:0] cnt_base;
  logic [wltm_pkg::CntW-1:0] cnt_after;
  logic                      any_len;
  assign cnt_base  = done_q ? '0 : count_q;
  assign cnt_after = (cnt_base < wltm_pkg::CntW'(wltm_pkg::MsgMax)) ? cnt_base + 1'b1
                                                                    : cnt_base;
  always_comb begin
    any_len = 1'b0;
    for (int i = 0; i < wltm_pkg::WordSlots; i++) begin
      if (len_q[i] != '0) any_len = 1'b1;
    end
  end
  assign stat_o.need_mask = (cmd_q.opcode == wltm_pkg::OpPush) && cmd_q.last &&
                            (filter_level_i != wltm_pkg::LevelNone) && mature_on_i && any_len;

  // current slot info and compare position
  logic [wltm_pkg::LenW-1:0]  cur_len;
  logic                       slot_off;
  logic [wltm_pkg::CntW:0]    end_pos;
  logic [wltm_pkg::CntW-1:0]  at;
  logic                       last_slot;
  assign cur_len   = len_q[s_q];
  assign slot_off  = (cur_len == '0) || skip_q[s_q];
  assign end_pos   = {1'b0, pos_q} + (wltm_pkg::CntW+1)'(cur_len);
  assign at        = pos_q + wltm_pkg::CntW'(k_q);
  assign last_slot = (s_q == wltm_pkg::SlotW'(wltm_pkg::WordSlots-1));
  assign stat_o.scan_done = scan_end_q;

  // word table writes and registered character read
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_cmd && cmd_q.opcode == wltm_pkg::OpWordByte &&
        cmd_q.position < 8'(wltm_pkg::WordMax)) begin
      word_mem[WaddrW'({cmd_q.slot, cmd_q.position[wltm_pkg::WposW-1:0]})] <= cmd_q.data_byte;
    end
    wb_q <= word_mem[{s_q, k_q[wltm_pkg::WposW-1:0]}];
  end

  // message buffer writes: push or fill; registered character read
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_cmd && cmd_q.opcode == wltm_pkg::OpPush &&
        cnt_base < wltm_pkg::CntW'(wltm_pkg::MsgMax)) begin
      msg_mem[cnt_base[wltm_pkg::MposW-1:0]] <= cmd_q.data_byte;
    end else if (cmd_i.cmp_step && fill_mode_q && !scan_end_q) begin
      msg_mem[at[wltm_pkg::MposW-1:0]] <= fill_q;
    end
    mb_q <= msg_mem[at[wltm_pkg::MposW-1:0]];
  end

  // control registers of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wltm_pkg::WordSlots; i++) len_q[i] <= '0;
      skip_q      <= '0;
      count_q     <= '0;
      done_q      <= 1'b1;
      ovf_q       <= 1'b0;
      rd_q        <= '0;
      s_q         <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      fill_mode_q <= 1'b0;
      fetched_q   <= 1'b0;
      scan_end_q  <= 1'b0;
      fill_q      <= wltm_pkg::FillLight;
    end else begin
      if (cmd_i.do_cmd) begin
        if (cmd_q.opcode == wltm_pkg::OpRead && 9'(cmd_q.position) < count_q) begin
          rd_q <= msg_mem[cmd_q.position];
        end else begin
          rd_q <= '0;
        end
        case (cmd_q.opcode)
          wltm_pkg::OpWordLen: begin
            len_q[cmd_q.slot] <= (cmd_q.word_length > 5'(wltm_pkg::WordMax))
                                 ? 5'(wltm_pkg::WordMax) : cmd_q.word_length;
            skip_q[cmd_q.slot] <= cmd_q.skip_word;
          end
          wltm_pkg::OpPush: begin
            count_q <= cnt_after;
            ovf_q   <= (done_q ? 1'b0 : ovf_q) |
                       (cnt_base >= wltm_pkg::CntW'(wltm_pkg::MsgMax));
            done_q  <= cmd_q.last;
          end
          default: ;
        endcase
      end
      if (cmd_i.mask_begin) begin
        s_q         <= '0;
        pos_q       <= '0;
        k_q         <= '0;
        fill_mode_q <= 1'b0;
        fetched_q   <= 1'b0;
        scan_end_q  <= 1'b0;
        fill_q      <= (filter_level_i == wltm_pkg::LevelHeavy) ? wltm_pkg::FillHeavy
                                                                 : wltm_pkg::FillLight;
      end else if (cmd_i.cmp_step && !scan_end_q) begin
        if (fill_mode_q) begin
          // one fill byte per cycle
          if (k_q + 1'b1 == (wltm_pkg::WposW+1)'(cur_len)) begin
            fill_mode_q <= 1'b0;
            k_q         <= '0;
            pos_q       <= end_pos[wltm_pkg::CntW-1:0];
          end else begin
            k_q <= k_q + 1'b1;
          end
        end else if (slot_off || end_pos > {1'b0, count_q}) begin
          // slot finished
          pos_q     <= '0;
          k_q       <= '0;
          fetched_q <= 1'b0;
          if (last_slot) scan_end_q <= 1'b1;
          else           s_q <= s_q + 1'b1;
        end else if (!fetched_q) begin
          // both characters land in mb_q/wb_q at this edge
          fetched_q <= 1'b1;
        end else if (wltm_pkg::fold_case(mb_q) != wltm_pkg::fold_case(wb_q)) begin
          fetched_q <= 1'b0;
          k_q       <= '0;
          pos_q     <= pos_q + 1'b1;
        end else if (k_q + 1'b1 == (wltm_pkg::WposW+1)'(cur_len)) begin
          fetched_q   <= 1'b0;
          fill_mode_q <= 1'b1;
          k_q         <= '0;
        end else begin
          fetched_q <= 1'b0;
          k_q       <= k_q + 1'b1;
        end
      end
    end
  end

  assign res_valid_o          = cmd_i.result;
  assign res_o.read_byte      = rd_q;
  assign res_o.message_length = count_q;
  assign res_o.done_res       = done_q;
  assign res_o.overflow       = ovf_q;

endmodule

// ===== rtl/core/word_list_text_masker_top.sv =====
// Top level: config registers, controller and datapath.
// Word writes, reads and plain pushes go from the execute state straight to the result
// strobe; a new word is accepted only once the block is idle again. A push marked last
// with masking enabled and a word defined scans every slot: each character compare is a
// registered fetch, then a compare; a matched word is then overwritten with fill bytes.
// busy is high from accept until the result cycle; the receiver cannot stall.
// Reset: slots empty, message done, level 2, mature on; buffers are not cleared.
module word_list_text_masker_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  wltm_pkg::in_word_t   in_word_i,
  output logic                 res_strobe_o,
  output wltm_pkg::out_word_t  res_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [1:0] filter_level_q;
  logic       mature_on_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_level_q <= 2'd2;
      mature_on_q    <= 1'b1;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        wltm_pkg::RegFilterLevel: filter_level_q <= pwdata[1:0];
        wltm_pkg::RegMatureOn:    mature_on_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      wltm_pkg::RegFilterLevel: prdata = {30'd0, filter_level_q};
      wltm_pkg::RegMatureOn:    prdata = {31'd0, mature_on_q};
      default: ;
    endcase
  end

  wltm_pkg::ctl_cmd_t cmd;
  wltm_pkg::dp_stat_t stat;

  wltm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  wltm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .in_i           (in_word_i),
    .filter_level_i (filter_level_q),
    .mature_on_i    (mature_on_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .res_valid_o    (res_strobe_o),
    .res_o          (res_word_o)
  );

endmodule

// ===== rtl/core/wltm_checker.sv =====
// Port-level checker for the masker, bound to the top level.
module wltm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                res_strobe_o,
  input wltm_pkg::out_word_t res_word_o
);

  // an accepted word makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // a result only comes while busy
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy) else $error("result strobe while idle");

  // after a result the block is free
  a_strobe_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !busy) else $error("busy after result");

  // length never exceeds capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> res_word_o.message_length <= 9'(wltm_pkg::MsgMax))
    else $error("message length above capacity");

endmodule

bind word_list_text_masker_top wltm_checker u_wltm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .res_word_o   (res_word_o)
);

// ===== sim/masker_checker.sv =====
// Checker for the word list text masker: mirrors the block, predicts each result word, compares.
module masker_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  wltm_pkg::in_word_t   in_word_i,
  input  logic                 res_strobe_o,
  input  wltm_pkg::out_word_t  res_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   fail_count_o,
  output int                   pending_o
);
  import wltm_pkg::*;

  // mirrored state
  logic [7:0] slot_chars [WordSlots][WordMax];
  int         slot_len   [WordSlots];
  logic       slot_skip  [WordSlots];
  logic [7:0] msg_buf    [MsgMax];
  int         msg_count;
  logic       msg_done;
  logic       msg_ovf;
  logic [1:0] level;
  logic       mature;

  out_word_t  expected_words [$];
  int         fails;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // overwrite every listed word not marked skip in the held message
  function automatic void mask_held_message();
    bit         any;
    bit         hit;
    logic [7:0] fill;
    int         len;
    int         pos;
    any = 0;
    if (level == LevelNone || !mature) return;
    for (int s = 0; s < WordSlots; s++) if (slot_len[s] != 0) any = 1;
    if (!any) return;
    fill = (level == LevelHeavy) ? FillHeavy : FillLight;
    for (int s = 0; s < WordSlots; s++) begin
      len = slot_len[s];
      if (len == 0 || slot_skip[s]) continue;
      pos = 0;
      while (pos + len <= msg_count) begin
        hit = 1;
        for (int k = 0; k < len; k++)
          if (to_lower(msg_buf[pos + k]) != to_lower(slot_chars[s][k])) hit = 0;
        if (hit) begin
          for (int k = 0; k < len; k++) msg_buf[pos + k] = fill;
          pos += len;
        end else begin
          pos++;
        end
      end
    end
  endfunction

  // apply one command word and form its result word
  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t r;
    r = '0;
    case (w.opcode)
      OpWordByte: begin
        if (w.position < WordMax) slot_chars[w.slot][w.position[3:0]] = w.data_byte;
      end
      OpWordLen: begin
        slot_len[w.slot]  = (w.word_length > WordMax) ? WordMax : w.word_length;
        slot_skip[w.slot] = w.skip_word;
      end
      OpPush: begin
        if (msg_done) begin
          msg_count = 0;
          msg_ovf   = 0;
          msg_done  = 0;
        end
        if (msg_count < MsgMax) begin
          msg_buf[msg_count] = w.data_byte;
          msg_count++;
        end else begin
          msg_ovf = 1;
        end
        if (w.last) begin
          mask_held_message();
          msg_done = 1;
        end
      end
      default: begin
        if (w.position < msg_count) r.read_byte = msg_buf[w.position];
      end
    endcase
    r.message_length = msg_count[8:0];
    r.done_res       = msg_done;
    r.overflow       = msg_ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    out_word_t new_w;
    if (!rst_ni) begin
      for (int s = 0; s < WordSlots; s++) begin
        slot_len[s]  = 0;
        slot_skip[s] = 0;
      end
      msg_count = 0;
      msg_done  = 1;
      msg_ovf   = 0;
      level     = 2'd2;
      mature    = 1'b1;
      fails     = 0;
      expected_words.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(4 * RegFilterLevel)) level = pwdata[1:0];
        if (paddr == 3'(4 * RegMatureOn)) mature = pwdata[0];
      end
      // compare result word with oldest prediction
      if (res_strobe_o) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $realtime, res_word_o);
          fails++;
        end else begin
          exp_w = expected_words.pop_front();
          if (res_word_o.read_byte !== exp_w.read_byte) begin
            $display("%0t: read_byte exp %h got %h", $realtime, exp_w.read_byte,
                     res_word_o.read_byte);
            fails++;
          end
          if (res_word_o.message_length !== exp_w.message_length) begin
            $display("%0t: message_length exp %0d got %0d", $realtime,
                     exp_w.message_length, res_word_o.message_length);
            fails++;
          end
          if (res_word_o.done_res !== exp_w.done_res) begin
            $display("%0t: done_res exp %b got %b", $realtime, exp_w.done_res,
                     res_word_o.done_res);
            fails++;
          end
          if (res_word_o.overflow !== exp_w.overflow) begin
            $display("%0t: overflow exp %b got %b", $realtime, exp_w.overflow,
                     res_word_o.overflow);
            fails++;
          end
        end
      end
      // accepted command word
      if (start && !busy) begin
        new_w = apply_command(in_word_i);
        expected_words = {expected_words, new_w};
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_words.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives commands and register writes into the masker, gives the verdict.
module tb;
  import wltm_pkg::*;

  localparam int IdleLimit = 1000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_word_t   in_word = '0;
  logic       res_strobe;
  out_word_t  res_word;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;
  int         fail_count;
  int         pending;
  int         gap_pct = 0;
  int         items = 0;
  int         idle_cycles = 0;

  word_list_text_masker_top dut (
    .clk_i, .rst_ni, .start, .busy, .in_word_i(in_word),
    .res_strobe_o(res_strobe), .res_word_o(res_word),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  masker_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .in_word_i(in_word),
    .res_strobe_o(res_strobe), .res_word_o(res_word),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: cycles with no accepted word and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one command word, wait for accept, then maybe idle
  task automatic issue(input in_word_t w);
    int gap;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (busy);
    items++;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random filler for fields the opcode ignores
  function automatic in_word_t noise_word(input logic [1:0] op);
    in_word_t    w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.opcode = op;
    return w;
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      case ($urandom_range(3))
        0:       return "a";
        1:       return "b";
        2:       return "A";
        default: return "B";
      endcase
    end
    if (r < 80) return "x";
    return 8'($urandom);
  endfunction

  task automatic define_word(input int slot, input int len, input bit skip);
    in_word_t w;
    int n;
    n = (len > WordMax) ? WordMax : len;
    for (int k = 0; k < n; k++) begin
      w = noise_word(OpWordByte);
      w.slot = 4'(slot);
      w.position = 8'(k);
      w.data_byte = ($urandom_range(9) < 8) ? text_char() : 8'($urandom);
      issue(w);
    end
    w = noise_word(OpWordLen);
    w.slot = 4'(slot);
    w.word_length = 5'(len);
    w.skip_word = skip;
    issue(w);
  endtask

  task automatic push_message(input int n);
    in_word_t w;
    for (int k = 0; k < n; k++) begin
      w = noise_word(OpPush);
      w.data_byte = text_char();
      w.last = (k == n - 1);
      issue(w);
    end
  endtask

  task automatic read_back(input int pos);
    in_word_t w;
    w = noise_word(OpRead);
    w.position = 8'(pos);
    issue(w);
  endtask

  // drain all results and let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(input int quota);
    int r;
    int n;
    while (items < quota) begin
      r = $urandom_range(99);
      if (r < 25) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 3);
        define_word($urandom_range(15), n, $urandom_range(5) == 0);
      end else if (r < 75) begin
        n = ($urandom_range(59) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 24);
        push_message(n);
        repeat ($urandom_range(1, 4)) read_back($urandom_range(0, 28));
      end else if (r < 90) begin
        read_back($urandom_range(255));
      end else begin
        // writes past the word end are ignored; in-range ones overwrite
        issue(noise_word(OpWordByte));
      end
    end
  endtask

  initial begin
    int ok;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: read before any message, saturated length, skip, reads past the message end
    read_back(0);
    push_message(3);
    define_word(0, 2, 1'b0);
    define_word(1, 2, 1'b1);
    define_word(15, 31, 1'b0);
    push_message(6);
    read_back(0);
    read_back(5);
    read_back(6);
    read_back(255);
    define_word(15, 0, 1'b0);

    wait_idle();
    reg_write(3'(4 * RegFilterLevel), 32'd2);
    reg_write(3'(4 * RegMatureOn), 32'd1);
    gap_pct = 0;
    random_phase(400);

    wait_idle();
    reg_write(3'(4 * RegFilterLevel), {30'h3fffffff, LevelHeavy});
    gap_pct = 80;
    random_phase(800);

    wait_idle();
    reg_write(3'(4 * RegFilterLevel), 32'd1);
    reg_write(3'(4 * RegMatureOn), 32'd0);
    gap_pct = 22;
    random_phase(1150);

    wait_idle();
    reg_write(3'(4 * RegFilterLevel), 32'(LevelNone));
    reg_write(3'(4 * RegMatureOn), 32'hffffffff);
    gap_pct = 0;
    random_phase(1350);

    wait_idle();
    reg_write(3'(4 * RegFilterLevel), 32'(LevelHeavy));
    gap_pct = 22;
    random_phase(1550);

    wait_idle();
    repeat (20) @(posedge clk_i);
    ok = (fail_count == 0) && (pending == 0);
    if (ok) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wltm_pkg.sv
rtl/core/wltm_ctrl.sv
rtl/core/wltm_dp.sv
rtl/core/word_list_text_masker_top.sv
rtl/core/wltm_checker.sv
sim/masker_checker.sv
sim/tb.sv
